// ===== sv/wcg_pkg.sv =====
// Shared types, constants and the arctangent table of the window coefficient generator.
`timescale 1ns / 1ps
package wcg_pkg;

	localparam int MAX_LENGTH     = 4096;
	localparam int COEF_FRAC_BITS = 16;

	localparam int IDX_W  = 12;
	localparam int LEN_W  = 13;
	localparam int COEF_W = COEF_FRAC_BITS + 1;

	// Long division: numerator, divisor and quotient widths.
	localparam int NUM_W = IDX_W + 32;
	localparam int DIV_W = 25;
	localparam int QUO_W = 33;
	localparam int CMP_W = DIV_W + QUO_W;

	// CORDIC datapath.
	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 34;

	localparam logic signed [CW-1:0] Q30_ONE     = CW'(64'sd1073741824);
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);
	localparam logic [30:0]          PIHALF_Q30  = 31'd1686629713;
	localparam logic signed [CW-1:0] ALPHA_Q30   = CW'(64'sd578059648);
	localparam logic signed [30:0]   BETA_Q30    = 31'sd495682176;

	localparam int ROUND_SH = 30 - COEF_FRAC_BITS;

	typedef enum logic [2:0] {
		WIN_RECT    = 3'd0,
		WIN_TRI     = 3'd1,
		WIN_WELCH   = 3'd2,
		WIN_HANN    = 3'd3,
		WIN_HAMMING = 3'd4
	} win_type_t;

	localparam logic REG_WINDOW_TYPE   = 1'b0;
	localparam logic REG_WINDOW_LENGTH = 1'b1;

	// Control travelling alongside each word through the cell chains.
	typedef struct packed {
		logic              valid;
		logic              oor;
		logic [2:0]        wtype;
		logic [1:0]        quad;
		logic [COEF_W-1:0] coef;
	} side_t;

	function automatic logic signed [CW-1:0] atan_q30(input int k);
		logic signed [CW-1:0] a;
		case (k)
			0:  a = CW'(64'sd843314856);
			1:  a = CW'(64'sd497837829);
			2:  a = CW'(64'sd263043836);
			3:  a = CW'(64'sd133525158);
			4:  a = CW'(64'sd67021686);
			5:  a = CW'(64'sd33543515);
			6:  a = CW'(64'sd16775850);
			7:  a = CW'(64'sd8388437);
			8:  a = CW'(64'sd4194282);
			9:  a = CW'(64'sd2097149);
			10: a = CW'(64'sd1048575);
			11: a = CW'(64'sd524287);
			12: a = CW'(64'sd262143);
			13: a = CW'(64'sd131071);
			14: a = CW'(64'sd65535);
			15: a = CW'(64'sd32767);
			16: a = CW'(64'sd16383);
			17: a = CW'(64'sd8191);
			18: a = CW'(64'sd4095);
			19: a = CW'(64'sd2047);
			20: a = CW'(64'sd1023);
			21: a = CW'(64'sd511);
			22: a = CW'(64'sd255);
			23: a = CW'(64'sd127);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== sv/wcg_div_cell.sv =====
// One restoring long-division cell: settles a single quotient bit per word.
`timescale 1ns / 1ps
module wcg_div_cell import wcg_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  side_t            side_in,
	input  logic [NUM_W-1:0] rem_in,
	input  logic [DIV_W-1:0] div_in,
	input  logic [QUO_W-1:0] quo_in,
	output side_t            side_out,
	output logic [NUM_W-1:0] rem_out,
	output logic [DIV_W-1:0] div_out,
	output logic [QUO_W-1:0] quo_out
);

	side_t            side_s1;
	logic [NUM_W-1:0] rem_s1;
	logic [DIV_W-1:0] div_s1;
	logic [QUO_W-1:0] quo_s1;

	logic [CMP_W-1:0] trial;
	logic             fits;

	assign trial = CMP_W'(div_in) << BIT;
	assign fits  = CMP_W'(rem_in) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s1 <= div_in;
			if (fits) begin
				rem_s1 <= rem_in - trial[NUM_W-1:0];
				quo_s1 <= quo_in | (QUO_W'(1) << BIT);
			end else begin
				rem_s1 <= rem_in;
				quo_s1 <= quo_in;
			end
		end
	end

	assign side_out = side_s1;
	assign rem_out  = rem_s1;
	assign div_out  = div_s1;
	assign quo_out  = quo_s1;

endmodule

// ===== sv/wcg_cordic_cell.sv =====
// One CORDIC rotation cell with a fixed shift and arctangent.
`timescale 1ns / 1ps
module wcg_cordic_cell import wcg_pkg::*; #(
	parameter int K = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  side_t                side_in,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] z_in,
	output side_t                side_out,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic signed [CW-1:0] z_out
);

	localparam logic signed [CW-1:0] ATAN = atan_q30(K);

	side_t                side_s1;
	logic signed [CW-1:0] x_s1, y_s1, z_s1;
	logic signed [CW-1:0] xs, ys;

	// Arithmetic shifts round towards minus infinity.
	assign xs = x_in >>> K;
	assign ys = y_in >>> K;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[CW-1]) begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - ATAN;
			end else begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + ATAN;
			end
		end
	end

	assign side_out = side_s1;
	assign x_out    = x_s1;
	assign y_out    = y_s1;
	assign z_out    = z_s1;

endmodule

// ===== sv/window_coefficient_generator.sv =====
// Top level: window coefficient pipeline built from division and CORDIC cell chains.
// Throughput is one word per cycle; the whole pipeline holds only while the output
// register is full and not taken. The divider takes 33 cells, the CORDIC 24.
// Reset clears all valid flags and sets the window type to rectangular, length 1024.
`timescale 1ns / 1ps
module window_coefficient_generator import wcg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [LEN_W-1:0]  cfg_data,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  logic [IDX_W-1:0]  sample_index,
	output logic              coef_valid,
	input  logic              coef_ready,
	output logic [COEF_W-1:0] coefficient,
	output logic              index_out_of_range
);

	logic [2:0]       window_type_q;
	logic [LEN_W-1:0] window_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_type_q   <= WIN_RECT;
			window_length_q <= LEN_W'(1024);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WINDOW_TYPE:   window_type_q   <= cfg_data[2:0];
				REG_WINDOW_LENGTH: window_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;

	assign en           = !out_valid_q || coef_ready;
	assign sample_ready = en;

	// Stage 1: length clamp and range check.
	logic [LEN_W-1:0] n_clamp;
	side_t            side_s1;
	logic [IDX_W-1:0] i_s1;
	logic [LEN_W-1:0] n_s1;

	always_comb begin
		if (window_length_q < LEN_W'(2))
			n_clamp = LEN_W'(2);
		else if (window_length_q > LEN_W'(MAX_LENGTH))
			n_clamp = LEN_W'(MAX_LENGTH);
		else
			n_clamp = window_length_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1.valid <= sample_valid;
			side_s1.oor   <= LEN_W'(sample_index) >= n_clamp;
			side_s1.wtype <= window_type_q;
			side_s1.quad  <= '0;
			side_s1.coef  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1 <= sample_index;
			n_s1 <= n_clamp;
		end
	end

	// Stage 2: triangle value and squares for the Welch window.
	logic [IDX_W-1:0]      m1;
	logic signed [LEN_W:0] d1;
	logic [LEN_W-1:0]      ad1;
	logic [LEN_W:0]        np1;

	assign m1  = IDX_W'(n_s1 - LEN_W'(1));
	assign d1  = $signed({1'b0, i_s1, 1'b0}) - $signed((LEN_W+1)'(m1));
	assign ad1 = d1[LEN_W] ? LEN_W'(-d1) : LEN_W'(d1);
	assign np1 = (LEN_W+1)'(n_s1) + (LEN_W+1)'(1);

	side_t            side_s2;
	logic [IDX_W-1:0] i_s2, m_s2, tri_s2;
	logic [DIV_W-1:0] b2_s2, dsq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (en) begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s2   <= i_s1;
			m_s2   <= m1;
			tri_s2 <= m1 - ad1[IDX_W-1:0];
			b2_s2  <= DIV_W'(np1) * DIV_W'(np1);
			dsq_s2 <= DIV_W'(ad1) * DIV_W'(ad1);
		end
	end

	// Stage 3: numerator and divisor for the chosen window.
	logic [NUM_W-1:0] num2;
	logic [DIV_W-1:0] div2;

	always_comb begin
		num2 = '0;
		div2 = DIV_W'(1);
		if (!side_s2.oor) begin
			case (side_s2.wtype)
				WIN_TRI: begin
					num2 = (NUM_W'(tri_s2) << COEF_FRAC_BITS) + NUM_W'(m_s2 >> 1);
					div2 = DIV_W'(m_s2);
				end
				WIN_WELCH: begin
					num2 = (NUM_W'(b2_s2 - dsq_s2) << COEF_FRAC_BITS) + NUM_W'(b2_s2 >> 1);
					div2 = b2_s2;
				end
				WIN_HANN, WIN_HAMMING: begin
					num2 = NUM_W'(i_s2) << 32;
					div2 = DIV_W'(m_s2);
				end
				default: ;
			endcase
		end
	end

	side_t            side_s3;
	logic [NUM_W-1:0] num_s3;
	logic [DIV_W-1:0] div_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en) begin
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= num2;
			div_s3 <= div2;
		end
	end

	// Division chain, most significant quotient bit first.
	side_t            dside [0:QUO_W];
	logic [NUM_W-1:0] drem  [0:QUO_W];
	logic [DIV_W-1:0] ddiv  [0:QUO_W];
	logic [QUO_W-1:0] dquo  [0:QUO_W];

	assign dside[0] = side_s3;
	assign drem[0]  = num_s3;
	assign ddiv[0]  = div_s3;
	assign dquo[0]  = '0;

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		wcg_div_cell #(.BIT(QUO_W - 1 - g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.side_in  (dside[g]),
			.rem_in   (drem[g]),
			.div_in   (ddiv[g]),
			.quo_in   (dquo[g]),
			.side_out (dside[g+1]),
			.rem_out  (drem[g+1]),
			.div_out  (ddiv[g+1]),
			.quo_out  (dquo[g+1])
		);
	end

	// Phase to angle: the low 30 phase bits scaled by a quarter turn in radians.
	logic [QUO_W-1:0] qd;
	logic [60:0]      zprod;
	side_t            side_z;

	assign qd    = dquo[QUO_W];
	assign zprod = 61'(qd[29:0]) * 61'(PIHALF_Q30);

	always_comb begin
		side_z      = dside[QUO_W];
		side_z.quad = qd[31:30];
		side_z.coef = qd[COEF_W-1:0];
	end

	side_t                side_s4;
	logic signed [CW-1:0] z_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (en) begin
			side_s4 <= side_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s4 <= $signed(CW'(zprod[60:30]));
		end
	end

	// CORDIC chain.
	side_t                cside [0:CORDIC_STEPS];
	logic signed [CW-1:0] cx    [0:CORDIC_STEPS];
	logic signed [CW-1:0] cy    [0:CORDIC_STEPS];
	logic signed [CW-1:0] cz    [0:CORDIC_STEPS];

	assign cside[0] = side_s4;
	assign cx[0]    = CORDIC_GAIN;
	assign cy[0]    = '0;
	assign cz[0]    = z_s4;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		wcg_cordic_cell #(.K(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.side_in  (cside[k]),
			.x_in     (cx[k]),
			.y_in     (cy[k]),
			.z_in     (cz[k]),
			.side_out (cside[k+1]),
			.x_out    (cx[k+1]),
			.y_out    (cy[k+1]),
			.z_out    (cz[k+1])
		);
	end

	// Quadrant mapping and clamp to plus or minus one.
	logic signed [CW-1:0] cmap, cclamp;
	side_t                side_c;

	assign side_c = cside[CORDIC_STEPS];

	always_comb begin
		case (side_c.quad)
			2'd0:    cmap = cx[CORDIC_STEPS];
			2'd1:    cmap = -cy[CORDIC_STEPS];
			2'd2:    cmap = -cx[CORDIC_STEPS];
			default: cmap = cy[CORDIC_STEPS];
		endcase
		if (cmap > Q30_ONE)
			cclamp = Q30_ONE;
		else if (cmap < -Q30_ONE)
			cclamp = -Q30_ONE;
		else
			cclamp = cmap;
	end

	side_t                side_s5;
	logic signed [CW-1:0] c_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else if (en) begin
			side_s5 <= side_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5 <= cclamp;
		end
	end

	// Hann half-difference and the Hamming product.
	side_t                side_s6;
	logic signed [CW-1:0] hann_s6;
	logic signed [63:0]   prod_s6;
	logic signed [CW-1:0] hann_diff;

	assign hann_diff = Q30_ONE - c_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
		end else if (en) begin
			side_s6 <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hann_s6 <= hann_diff >>> 1;
			prod_s6 <= 64'(BETA_Q30) * 64'(c_s5);
		end
	end

	// Final clamp, rounding and selection.
	logic signed [CW-1:0] vsel, vclamp;
	logic [CW-1:0]        vround;
	logic [COEF_W-1:0]    coef_cos, coef_sel;

	always_comb begin
		if (side_s6.wtype == WIN_HAMMING)
			vsel = ALPHA_Q30 - CW'(prod_s6 >>> 30);
		else
			vsel = hann_s6;
		if (vsel < 0)
			vclamp = '0;
		else if (vsel > Q30_ONE)
			vclamp = Q30_ONE;
		else
			vclamp = vsel;
		vround   = (CW'(vclamp) + (CW'(1) << (ROUND_SH - 1))) >> ROUND_SH;
		coef_cos = vround[COEF_W-1:0];
		case (side_s6.wtype)
			WIN_TRI, WIN_WELCH:    coef_sel = side_s6.coef;
			WIN_HANN, WIN_HAMMING: coef_sel = coef_cos;
			default:               coef_sel = COEF_W'(1) << COEF_FRAC_BITS;
		endcase
		if (side_s6.oor)
			coef_sel = '0;
	end

	logic [COEF_W-1:0] coef_q;
	logic              oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_q <= coef_sel;
			oor_q  <= side_s6.oor;
		end
	end

	assign coef_valid         = out_valid_q;
	assign coefficient        = coef_q;
	assign index_out_of_range = oor_q;

endmodule

// ===== bench/window_coefficient_checker.sv =====
// Checker for the window coefficient generator: predicts each coefficient word and compares it.
`timescale 1ns / 1ps
module window_coefficient_checker import wcg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [LEN_W-1:0]  cfg_data,
	input  logic              sample_valid,
	input  logic              sample_ready,
	input  logic [IDX_W-1:0]  sample_index,
	input  logic              coef_valid,
	input  logic              coef_ready,
	input  logic [COEF_W-1:0] coefficient,
	input  logic              index_out_of_range,
	output int                fail_count,
	output int                pending_count
);

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic              oor;
	} coef_word_t;

	coef_word_t       expected_coefs[$];
	logic [2:0]       shadow_type;
	logic [LEN_W-1:0] shadow_length;

	localparam longint ONE_Q30 = 64'd1073741824;
	localparam longint GAIN_Q30 = 64'd652032874;
	localparam longint HALF_PI_Q30 = 64'd1686629713;
	localparam longint HAMMING_ALPHA = 64'd578059648;
	localparam longint HAMMING_BETA = ONE_Q30 - HAMMING_ALPHA;

	function automatic longint cosine_q30(longint idx, longint m);
		longint unsigned phase;
		longint x, y, z, xs, ys, c;
		logic [1:0] quadrant;
		phase = ((longint'(idx) << 32) / m) & 64'hFFFF_FFFF;
		quadrant = phase[31:30];
		z = longint'(((phase & 64'h3FFF_FFFF) * HALF_PI_Q30) >> 30);
		x = GAIN_Q30;
		y = 0;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - longint'(atan_q30(k));
			end else begin
				x = x + ys; y = y - xs; z = z + longint'(atan_q30(k));
			end
		end
		case (quadrant)
			2'd0: c = x;
			2'd1: c = -y;
			2'd2: c = -x;
			default: c = y;
		endcase
		if (c > ONE_Q30) c = ONE_Q30;
		if (c < -ONE_Q30) c = -ONE_Q30;
		return c;
	endfunction

	function automatic longint q30_rounded(longint v);
		if (v < 0) v = 0;
		if (v > ONE_Q30) v = ONE_Q30;
		return (v + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
	endfunction

	function automatic coef_word_t window_value(logic [IDX_W-1:0] idx);
		coef_word_t w;
		longint n, m, d, ad, b2, v;
		n = shadow_length;
		if (n < 2) n = 2;
		if (n > MAX_LENGTH) n = MAX_LENGTH;
		w.oor = 1'b0;
		if (idx >= n) begin
			w.coef = '0;
			w.oor = 1'b1;
			return w;
		end
		m = n - 1;
		d = 2 * longint'(idx) - m;
		case (shadow_type)
			WIN_TRI: begin
				ad = (d < 0) ? -d : d;
				v = ((m - ad) * (64'd1 << COEF_FRAC_BITS) + m / 2) / m;
			end
			WIN_WELCH: begin
				b2 = (n + 1) * (n + 1);
				v = ((b2 - d * d) * (64'd1 << COEF_FRAC_BITS) + b2 / 2) / b2;
			end
			WIN_HANN: v = q30_rounded((ONE_Q30 - cosine_q30(idx, m)) >>> 1);
			WIN_HAMMING:
				v = q30_rounded(HAMMING_ALPHA - ((HAMMING_BETA * cosine_q30(idx, m)) >>> 30));
			default: v = 64'd1 << COEF_FRAC_BITS;
		endcase
		w.coef = COEF_W'(v);
		return w;
	endfunction

	assign pending_count = expected_coefs.size();

	always @(posedge clk or negedge arst_n) begin
		coef_word_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			shadow_type <= WIN_RECT;
			shadow_length <= LEN_W'(1024);
			fail_count <= 0;
			expected_coefs.delete();
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_WINDOW_TYPE) shadow_type <= cfg_data[2:0];
				else shadow_length <= cfg_data;
			end
			if (sample_valid && sample_ready)
				expected_coefs.push_back(window_value(sample_index));
			if (coef_valid && coef_ready) begin
				if (expected_coefs.size() == 0) begin
					$error("coefficient word with nothing expected: coef %0d oor %0b",
						coefficient, index_out_of_range);
					errs = errs + 1;
				end else begin
					want = expected_coefs.pop_front();
					if (coefficient !== want.coef) begin
						$error("coefficient: expected %0d, actual %0d", want.coef, coefficient);
						errs = errs + 1;
					end
					if (index_out_of_range !== want.oor) begin
						$error("index_out_of_range: expected %0b, actual %0b",
							want.oor, index_out_of_range);
						errs = errs + 1;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== bench/window_coefficient_generator_tb.sv =====
// Testbench top: drives configuration, sample indices and output back-pressure.
`timescale 1ns / 1ps
module window_coefficient_generator_tb;
	import wcg_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic              cfg_index = REG_WINDOW_TYPE;
	logic [LEN_W-1:0]  cfg_data = '0;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	logic [IDX_W-1:0]  sample_index = '0;
	logic              coef_valid;
	logic              coef_ready = 1'b0;
	logic [COEF_W-1:0] coefficient;
	logic              index_out_of_range;
	int                fail_count;
	int                pending_count;
	int                words_taken = 0;
	int                hold_cycles = 0;
	bit                long_hold_done = 0;

	always #1 clk = ~clk;

	window_coefficient_generator dut (.*);
	window_coefficient_checker checker_i (.*);

	function automatic int gap_length();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// Receiver: random gaps, plus one long hold once the pipeline has been running a while.
	always @(negedge clk) begin
		if (coef_valid && coef_ready) words_taken <= words_taken + 1;
		if (!long_hold_done && words_taken == 400) begin
			long_hold_done <= 1;
			hold_cycles <= 300;
			coef_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			coef_ready <= 1'b0;
		end else begin
			coef_ready <= (gap_length() == 0);
		end
	end

	task automatic write_reg(logic idx, logic [LEN_W-1:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic drain();
		while (pending_count != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic send_index(logic [IDX_W-1:0] idx);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid = 1'b1;
		sample_index = idx;
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int lengths[10] = '{2, 3, 1024, 4096, 0, 1, 8191, 4097, 17, 255};
		int n;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Directed: every window type at the extremes of the index and length.
		for (int t = 0; t < 8; t++) begin
			write_reg(REG_WINDOW_TYPE, LEN_W'(t));
			foreach (lengths[j]) begin
				if (j > 3 && t != WIN_HANN) continue;
				write_reg(REG_WINDOW_LENGTH, LEN_W'(lengths[j]));
				n = (lengths[j] < 2) ? 2 : (lengths[j] > MAX_LENGTH ? MAX_LENGTH : lengths[j]);
				send_index(0);
				send_index(IDX_W'(n - 1));
				send_index(IDX_W'(n / 2));
				if (n < MAX_LENGTH) send_index(IDX_W'(n));
				send_index('1);
				sample_valid = 1'b0;
				drain();
			end
		end
		// Random phases: mostly in-range indices, some anywhere in the field.
		for (int phase = 0; phase < 24; phase++) begin
			write_reg(REG_WINDOW_TYPE, LEN_W'(phase < 20 ? phase % 5 : $urandom_range(0, 7)));
			case (phase % 4)
				0: n = $urandom_range(2, 40);
				1: n = $urandom_range(2, MAX_LENGTH);
				2: n = (phase % 8 == 2) ? MAX_LENGTH : 2;
				default: n = $urandom_range(0, 8191);
			endcase
			write_reg(REG_WINDOW_LENGTH, LEN_W'(n));
			if (n < 2) n = 2;
			if (n > MAX_LENGTH) n = MAX_LENGTH;
			repeat (72) begin
				if ($urandom_range(0, 9) == 0) send_index(IDX_W'($urandom_range(0, 4095)));
				else send_index(IDX_W'($urandom_range(0, n - 1)));
			end
			sample_valid = 1'b0;
			drain();
		end
		if (fail_count == 0 && pending_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/wcg_pkg.sv
sv/wcg_div_cell.sv
sv/wcg_cordic_cell.sv
sv/window_coefficient_generator.sv
bench/window_coefficient_checker.sv
bench/window_coefficient_generator_tb.sv
